// ----- rtl/core/avcs_pkg.sv -----
// shared types and constants for the ascending vc selector
// request and result payload structs, port classes, register indexes
// no dependencies
package avcs_pkg;

  // default sizing of the hop table and vc space
  localparam int MaxHopsDef = 8;
  localparam int VcCountDef = 16;

  // field widths fixed by the interface
  localparam int PortW     = 6;
  localparam int VcW       = 4;
  localparam int HopCountW = 4;
  localparam int HopMaskW  = 8;
  localparam int PortLimW  = 7;
  localparam int CfgIdxW   = 4;
  localparam int CfgDataW  = 8;

  // port classes
  typedef enum logic [2:0] {
    CLS_NODE,
    CLS_LOCAL,
    CLS_GLOBAL,
    CLS_NOTIFY,
    CLS_RING
  } cls_t;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_HOP_COUNT       = 4'd0,
    CFG_HOP_GLOBAL_MASK = 4'd1,
    CFG_NODE_PORT_LIMIT = 4'd2,
    CFG_GLOBAL_OFFSET   = 4'd3,
    CFG_GLOBAL_COUNT    = 4'd4,
    CFG_NOTIFY_ENABLE   = 4'd5,
    CFG_NOTIFY_PORT     = 4'd6,
    CFG_REACTIVE_MODE   = 4'd7
  } cfg_idx_t;

  // status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // incoming request
  typedef struct packed {
    logic [PortW-1:0] in_port;
    logic [PortW-1:0] out_port;
    logic [VcW-1:0]   in_vc;
    logic             is_response;
  } in_req_t;

  // outgoing result
  typedef struct packed {
    logic [VcW-1:0] next_vc;
    logic           status;
  } out_res_t;

endpackage

// ----- rtl/core/ascending_vc_selector.sv -----
// ascending virtual-channel selector, top level
// depends on avcs_pkg for payload types, port classes and register indexes
//
// Usage:
//   in_valid/in_ready carry one routing request (in/out port, current vc,
//   response flag). out_valid/out_ready return one result per request: the
//   vc for the output port and a status bit (1 = no legal later hop or vc
//   out of range, next_vc then 0).
//   cfg_valid/cfg_ready write the hop sequence and port thresholds; cfg_ready
//   is always high, writes to unknown indexes are dropped. Write only while
//   no request is in flight.
//   An accepted request waits in the request register until the result
//   register is free. Throughput: one request per cycle while out_ready
//   is high; all hop lanes are matched in parallel between the request
//   register and the result register.
//   Stalls: while out_ready is low the result holds, one more request may
//   sit in the request register, then in_ready drops.
//   Reset (rst_n low, synchronous) empties both stages and sets hop_count
//   to 1 and all other configuration registers to 0.
module ascending_vc_selector
  import avcs_pkg::*;
#(
  parameter int MAX_HOPS = MaxHopsDef,
  parameter int VC_COUNT = VcCountDef
) (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_ready,
  input  in_req_t             in_req,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output out_res_t            out_res,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // count and vc widths derived from the hop table size
  localparam int CntW  = $clog2(MAX_HOPS + 1);
  localparam int VcRaw = $clog2(2 * MAX_HOPS + 1);
  localparam int SelW  = (VcRaw > VcW) ? VcRaw : VcW;
  localparam int MaskW = (MAX_HOPS > HopMaskW) ? MAX_HOPS : HopMaskW;

  // configuration registers
  logic [HopCountW-1:0] hop_count_r;
  logic [HopMaskW-1:0]  hop_global_mask_r;
  logic [PortLimW-1:0]  node_port_limit_r;
  logic [PortLimW-1:0]  global_port_offset_r;
  logic [PortLimW-1:0]  global_port_count_r;
  logic                 notify_enable_r;
  logic [PortW-1:0]     notify_port_r;
  logic                 reactive_mode_r;

  // pipeline registers
  logic     s1_valid_r;
  logic     s1_valid_nxt;
  in_req_t  s1_req_r;
  logic     out_valid_r;
  logic     out_valid_nxt;
  out_res_t out_res_r;
  out_res_t out_res_nxt;

  logic out_free;
  logic s1_adv;
  logic in_acc;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hop_count_r          <= HopCountW'(1);
      hop_global_mask_r    <= '0;
      node_port_limit_r    <= '0;
      global_port_offset_r <= '0;
      global_port_count_r  <= '0;
      notify_enable_r      <= 1'b0;
      notify_port_r        <= '0;
      reactive_mode_r      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HOP_COUNT:       hop_count_r          <= cfg_data[HopCountW-1:0];
        CFG_HOP_GLOBAL_MASK: hop_global_mask_r    <= cfg_data[HopMaskW-1:0];
        CFG_NODE_PORT_LIMIT: node_port_limit_r    <= cfg_data[PortLimW-1:0];
        CFG_GLOBAL_OFFSET:   global_port_offset_r <= cfg_data[PortLimW-1:0];
        CFG_GLOBAL_COUNT:    global_port_count_r  <= cfg_data[PortLimW-1:0];
        CFG_NOTIFY_ENABLE:   notify_enable_r      <= cfg_data[0];
        CFG_NOTIFY_PORT:     notify_port_r        <= cfg_data[PortW-1:0];
        CFG_REACTIVE_MODE:   reactive_mode_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshake between the two stages
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // port classification against the threshold registers
  function automatic cls_t classify(
    input logic [PortW-1:0]    port,
    input logic [PortLimW-1:0] node_lim,
    input logic [PortLimW-1:0] glob_off,
    input logic [PortLimW-1:0] glob_cnt,
    input logic                ntf_en,
    input logic [PortW-1:0]    ntf_port
  );
    logic [PortLimW:0] glob_end;
    cls_t              c;
    glob_end = {1'b0, glob_off} + {1'b0, glob_cnt};
    if ({1'b0, port} < node_lim) begin
      c = CLS_NODE;
    end else if ({1'b0, port} < glob_off) begin
      c = CLS_LOCAL;
    end else if ({2'b00, port} < glob_end) begin
      c = CLS_GLOBAL;
    end else if (ntf_en && (port == ntf_port)) begin
      c = CLS_NOTIFY;
    end else begin
      c = CLS_RING;
    end
    return c;
  endfunction

  // hop lanes: vc numbering, input match and first later output match
  always_comb begin
    logic [MaskW-1:0]    mask_ext;
    logic [MAX_HOPS-1:0] lane_on;
    logic [MAX_HOPS-1:0] lane_glob;
    logic [MAX_HOPS-1:0] in_hit;
    logic [MAX_HOPS-1:0] cand;
    logic [MAX_HOPS-1:0] below;
    logic [CntW-1:0]     t_glob;
    logic [CntW-1:0]     t_loc;
    logic [CntW-1:0]     pre_glob;
    logic [CntW-1:0]     pre_loc;
    logic [SelW-1:0]     lane_vc [MAX_HOPS];
    logic [SelW-1:0]     sel_vc;
    logic                resp;
    logic                from_start;
    logic                ok;
    cls_t                in_cls;
    cls_t                out_cls;
    cls_t                lane_cls;

    resp     = s1_req_r.is_response && reactive_mode_r;
    mask_ext = MaskW'(hop_global_mask_r);
    in_cls   = classify(s1_req_r.in_port, node_port_limit_r, global_port_offset_r,
                        global_port_count_r, notify_enable_r, notify_port_r);
    out_cls  = classify(s1_req_r.out_port, node_port_limit_r, global_port_offset_r,
                        global_port_count_r, notify_enable_r, notify_port_r);
    from_start = (in_cls == CLS_NODE) || (in_cls == CLS_NOTIFY);

    // active lanes and their link class
    for (int i = 0; i < MAX_HOPS; i++) begin
      lane_on[i]   = int'(hop_count_r) > i;
      lane_glob[i] = mask_ext[i] && lane_on[i];
    end
    t_glob = CntW'($countones(lane_glob));
    t_loc  = CntW'($countones(lane_on)) - t_glob;

    // per lane vc and input match
    for (int i = 0; i < MAX_HOPS; i++) begin
      for (int j = 0; j < MAX_HOPS; j++) begin
        below[j] = (j < i);
      end
      pre_glob = CntW'($countones(lane_glob & below));
      pre_loc  = CntW'(i) - pre_glob;
      if (lane_glob[i]) begin
        lane_vc[i] = (resp ? SelW'(t_glob) : '0) + SelW'(pre_glob);
      end else begin
        lane_vc[i] = (resp ? SelW'(t_loc) : '0) + SelW'(pre_loc);
      end
      lane_cls  = lane_glob[i] ? CLS_GLOBAL : CLS_LOCAL;
      in_hit[i] = lane_on[i] && (lane_cls == in_cls)
                  && (lane_vc[i] == SelW'(s1_req_r.in_vc));
    end

    // a lane is a candidate if it follows the first input match
    for (int i = 0; i < MAX_HOPS; i++) begin
      for (int j = 0; j < MAX_HOPS; j++) begin
        below[j] = (j < i);
      end
      lane_cls = lane_glob[i] ? CLS_GLOBAL : CLS_LOCAL;
      cand[i]  = lane_on[i] && (lane_cls == out_cls)
                 && (from_start || ((in_hit & below) != '0));
    end

    // lowest candidate wins
    ok     = 1'b0;
    sel_vc = '0;
    for (int i = MAX_HOPS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        ok     = 1'b1;
        sel_vc = lane_vc[i];
      end
    end

    // node outputs keep the incoming vc
    if (out_cls == CLS_NODE) begin
      ok     = 1'b1;
      sel_vc = SelW'(s1_req_r.in_vc);
    end

    // range check
    if (ok && (int'(sel_vc) >= VC_COUNT)) begin
      ok = 1'b0;
    end

    out_res_nxt.next_vc = ok ? sel_vc[VcW-1:0] : '0;
    out_res_nxt.status  = ok ? STATUS_OK : STATUS_ERR;
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r <= in_req;
    end
    if (s1_adv) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef SYNTHESIS
  // an error result carries vc 0
  a_err_zero_vc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.status == STATUS_ERR)) |-> (out_res_r.next_vc == '0))
    else $error("error result with nonzero vc");

  // a good result lies inside the vc space
  a_vc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.status == STATUS_OK)) |-> (int'(out_res_r.next_vc) < VC_COUNT))
    else $error("selected vc out of range");

  // a request moving out of stage one becomes a visible result
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("request lost between stages");

  // backpressure only when stage one is occupied and the result is stuck
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("in_ready low without a full pipeline");

  // an accepted request is held in stage one next cycle
  a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted request not held");
`endif

endmodule

// ----- sim/tb_top.sv -----
// self-checking testbench for the ascending vc selector
// predicts next vc and status per request from its own copy of the registers
// depends on avcs_pkg and ascending_vc_selector
module tb_top
  import avcs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit   = 200000;
  localparam int ItemsPerPass = 128;
  localparam int PassCount    = 12;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_req_t             in_req = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_res_t            out_res;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // shadow copy of the selector registers
  logic [HopCountW-1:0] hop_count_r = 4'd1;
  logic [HopMaskW-1:0]  hop_mask_r = '0;
  logic [PortLimW-1:0]  node_lim_r = '0;
  logic [PortLimW-1:0]  goff_r = '0;
  logic [PortLimW-1:0]  gcnt_r = '0;
  logic                 notify_en_r = 1'b0;
  logic [PortW-1:0]     notify_port_r = '0;
  logic                 reactive_r = 1'b0;

  in_req_t  req_backlog[$];
  out_res_t routes_due[$];
  out_res_t route_want;
  bit       req_taken = 1'b0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  int       mismatches = 0;
  int       cycles = 0;

  ascending_vc_selector uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // port classification from the thresholds
  function automatic cls_t port_class(int p);
    if (p < int'(node_lim_r)) return CLS_NODE;
    if (p < int'(goff_r)) return CLS_LOCAL;
    if (p < int'(goff_r) + int'(gcnt_r)) return CLS_GLOBAL;
    if (notify_en_r && p == int'(notify_port_r)) return CLS_NOTIFY;
    return CLS_RING;
  endfunction

  function automatic int active_hops();
    return (int'(hop_count_r) > MaxHopsDef) ? MaxHopsDef : int'(hop_count_r);
  endfunction

  function automatic cls_t hop_kind(int i);
    return (i < HopMaskW && hop_mask_r[i]) ? CLS_GLOBAL : CLS_LOCAL;
  endfunction

  // vc of hop i: rank among hops of its kind, response set after request set
  function automatic int hop_vc_of(int i, bit resp);
    int n, rank, total;
    n = active_hops();
    rank = 0;
    total = 0;
    for (int j = 0; j < n; j++) begin
      if (hop_kind(j) == hop_kind(i)) begin
        total++;
        if (j < i) rank++;
      end
    end
    return resp ? total + rank : rank;
  endfunction

  // next vc for one routing request
  function automatic out_res_t select_vc(in_req_t r);
    out_res_t res;
    int n, start, vc;
    bit resp, found, ok;
    cls_t ic, oc;
    n = active_hops();
    resp = r.is_response && reactive_r;
    ic = port_class(int'(r.in_port));
    oc = port_class(int'(r.out_port));
    ok = 1'b0;
    found = 1'b0;
    start = 0;
    vc = 0;
    if (oc == CLS_NODE) begin
      ok = 1'b1;
      vc = int'(r.in_vc);
    end else begin
      // node and notification inputs sit before the first hop
      if (ic == CLS_NODE || ic == CLS_NOTIFY) begin
        found = 1'b1;
      end else begin
        for (int i = 0; i < n; i++) begin
          if (!found && hop_kind(i) == ic && hop_vc_of(i, resp) == int'(r.in_vc)) begin
            found = 1'b1;
            start = i + 1;
          end
        end
      end
      if (found) begin
        for (int i = start; i < n; i++) begin
          if (!ok && hop_kind(i) == oc) begin
            ok = 1'b1;
            vc = hop_vc_of(i, resp);
          end
        end
      end
    end
    if (ok && vc >= VcCountDef) ok = 1'b0;
    res.next_vc = ok ? vc[VcW-1:0] : '0;
    res.status  = ok ? STATUS_OK : STATUS_ERR;
    return res;
  endfunction

  // random port of a class, -1 when the class is empty
  function automatic int port_of_class(cls_t c);
    int hits, pick;
    hits = 0;
    for (int p = 0; p < (1 << PortW); p++)
      if (port_class(p) == c) hits++;
    if (hits == 0) return -1;
    pick = $urandom_range(hits - 1);
    for (int p = 0; p < (1 << PortW); p++) begin
      if (port_class(p) == c) begin
        if (pick == 0) return p;
        pick--;
      end
    end
    return -1;
  endfunction

  // mostly requests that sit on a hop and head for a later hop, rest noise
  function automatic in_req_t make_req();
    in_req_t r;
    int n, k, p;
    bit resp;
    cls_t c;
    r.in_port = PortW'($urandom);
    r.out_port = PortW'($urandom);
    r.in_vc = VcW'($urandom);
    r.is_response = 1'($urandom);
    if ($urandom_range(99) < 75) begin
      n = active_hops();
      resp = r.is_response && reactive_r;
      k = -1;
      if (n > 0 && $urandom_range(3) != 0) begin
        k = $urandom_range(n - 1);
        p = port_of_class(hop_kind(k));
        if (p >= 0) begin
          r.in_port = PortW'(p);
          r.in_vc = VcW'(hop_vc_of(k, resp));
        end
      end else begin
        p = port_of_class($urandom_range(1) ? CLS_NODE : CLS_NOTIFY);
        if (p >= 0) r.in_port = PortW'(p);
      end
      if (k + 1 < n && $urandom_range(3) != 0) c = hop_kind($urandom_range(n - 1, k + 1));
      else c = cls_t'($urandom_range(4));
      p = port_of_class(c);
      if (p >= 0) r.out_port = PortW'(p);
    end
    return r;
  endfunction

  task automatic add_req(int ip, int op, int vc, bit resp);
    in_req_t r;
    r.in_port = PortW'(ip);
    r.out_port = PortW'(op);
    r.in_vc = VcW'(vc);
    r.is_response = resp;
    req_backlog.insert(req_backlog.size(), r);
  endtask

  // hold until nothing is queued, offered or outstanding
  task automatic wait_idle();
    while (req_backlog.size() != 0 || in_valid || routes_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // one register write, shadow copy follows at the accepting edge
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_HOP_COUNT:       hop_count_r = val[HopCountW-1:0];
      CFG_HOP_GLOBAL_MASK: hop_mask_r = val[HopMaskW-1:0];
      CFG_NODE_PORT_LIMIT: node_lim_r = val[PortLimW-1:0];
      CFG_GLOBAL_OFFSET:   goff_r = val[PortLimW-1:0];
      CFG_GLOBAL_COUNT:    gcnt_r = val[PortLimW-1:0];
      CFG_NOTIFY_ENABLE:   notify_en_r = val[0];
      CFG_NOTIFY_PORT:     notify_port_r = val[PortW-1:0];
      CFG_REACTIVE_MODE:   reactive_r = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_all(int hops, int mask, int nlim, int goff, int gcnt,
                         int nen, int nport, int react);
    write_reg(CFG_HOP_COUNT, CfgDataW'(hops));
    write_reg(CFG_HOP_GLOBAL_MASK, CfgDataW'(mask));
    write_reg(CFG_NODE_PORT_LIMIT, CfgDataW'(nlim));
    write_reg(CFG_GLOBAL_OFFSET, CfgDataW'(goff));
    write_reg(CFG_GLOBAL_COUNT, CfgDataW'(gcnt));
    write_reg(CFG_NOTIFY_ENABLE, CfgDataW'(nen));
    write_reg(CFG_NOTIFY_PORT, CfgDataW'(nport));
    write_reg(CFG_REACTIVE_MODE, CfgDataW'(react));
    // unknown index must leave every register alone
    write_reg(CfgIdxW'(CFG_REACTIVE_MODE) + CfgIdxW'($urandom_range(8, 1)),
              CfgDataW'($urandom));
  endtask

  task automatic rand_setting();
    int hops, nlim, goff, gcnt;
    hops = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(MaxHopsDef, 1);
    nlim = $urandom_range(24);
    goff = nlim + $urandom_range(24);
    gcnt = $urandom_range(24);
    if ($urandom_range(7) == 0) begin
      nlim = $urandom_range(127);
      goff = $urandom_range(127);
      gcnt = $urandom_range(127);
    end
    set_all(hops, $urandom_range(255), nlim, goff, gcnt, $urandom_range(1),
            $urandom_range(63), $urandom_range(1));
  endtask

  // request driver: record acceptance at the rising edge, drive at the falling
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      routes_due.insert(routes_due.size(), select_vc(in_req));
      req_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || req_taken)) begin
      req_taken = 1'b0;
      if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_req <= req_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (routes_due.size() == 0) begin
        $error("result with no request outstanding: next_vc=%0d status=%0d",
               out_res.next_vc, out_res.status);
        mismatches++;
      end else begin
        route_want = routes_due.pop_front();
        if (out_res.next_vc !== route_want.next_vc) begin
          $error("next_vc mismatch: expected %0d, got %0d", route_want.next_vc, out_res.next_vc);
          mismatches++;
        end
        if (out_res.status !== route_want.status) begin
          $error("status mismatch: expected %0d, got %0d", route_want.status, out_res.status);
          mismatches++;
        end
      end
    end
  end

  // run limit
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // reset, then register settings each followed by a batch of requests
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < PassCount; ph++) begin
      wait_idle();
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 75; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 75; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      case (ph)
        0: ;  // reset values
        1: begin
          // hops local, global, global, local, global; two unused mask bits set
          set_all(5, 8'h56, 8, 24, 16, 1, 50, 1);
          write_reg(CFG_HOP_GLOBAL_MASK, 8'hD6);
          add_req(0, 10, 9, 0);     // node input to first local hop
          add_req(50, 30, 0, 0);    // notification input to first global hop
          add_req(8, 39, 0, 0);     // local hop 0 to global hop 1
          add_req(24, 23, 1, 0);    // global hop 2 to local hop 3
          add_req(39, 24, 2, 0);    // last hop, nothing later
          add_req(12, 30, 5, 0);    // vc on no hop
          add_req(45, 10, 0, 0);    // ring input
          add_req(63, 7, 15, 0);    // node output keeps the vc
          add_req(10, 0, 0, 1);
          add_req(0, 50, 0, 0);     // notification output
          add_req(0, 63, 0, 0);     // ring output
          add_req(8, 24, 2, 1);     // response set, local to global
          add_req(24, 8, 4, 1);     // response set, global to local
          add_req(24, 8, 1, 1);     // request vc under a response flit
          add_req(63, 63, 15, 1);
          add_req(0, 0, 0, 0);
          add_req(50, 8, 15, 1);
          wait_idle();
          // response flits fall back to the request set
          write_reg(CFG_REACTIVE_MODE, '0);
          add_req(8, 24, 0, 1);
          add_req(23, 24, 2, 1);
        end
        2: set_all(8, 8'h7F, 0, 0, 64, 1, 63, 1);
        3: set_all(0, 0, 16, 32, 16, 1, 0, 0);
        4: set_all(15, 8'h2A, 4, 20, 40, 1, 63, 1);
        5: set_all(8, 8'h0F, 64, 64, 64, 0, 0, 1);
        6: set_all(1, 1, 0, 127, 0, 1, 5, 0);
        7: set_all(8, 8'h55, 127, 127, 127, 1, 63, 1);
        default: rand_setting();
      endcase
      if (ph == 2) write_reg(CFG_HOP_GLOBAL_MASK, 8'hFF);
      for (int i = 0; i < ItemsPerPass; i++) begin
        // sender holds off until every result is back
        if ((ph == 4 || ph == 9) && i == ItemsPerPass / 2) wait_idle();
        req_backlog.insert(req_backlog.size(), make_req());
      end
    end
    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
